[src/e2rm_pkg.sv]
// Shared types, constants and arithmetic helpers for the Euler angle to
// rotation matrix core. No dependencies.
`default_nettype none
package e2rm_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int COEF_W         = COEF_FRAC_BITS + 2;

	// One full turn and one quarter turn in degrees times 64.
	localparam longint TURN_UNITS    = 23040;
	localparam longint QUARTER_UNITS = 5760;

	// Offset that makes every input angle non-negative without changing it modulo a turn.
	localparam longint ANG_HALF   = longint'(1) << (ANGLE_BITS - 1);
	localparam longint ANG_OFFSET = ((ANG_HALF + TURN_UNITS - 1) / TURN_UNITS) * TURN_UNITS;
	localparam int     UW         = $clog2(ANG_OFFSET + ANG_HALF);
	localparam int     RSH        = UW + 1;
	localparam longint RECIP      = (longint'(1) << RSH) / TURN_UNITS;
	localparam int     RW         = $clog2(RECIP + 1);
	localparam int     QW         = UW - 14;

	localparam int CORDIC_STEPS    = 16;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int ZW              = 25;
	localparam int XW              = 34;
	localparam int TW              = 32;
	localparam int PW              = 64;

	localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(652032874);
	localparam logic signed [TW-1:0] ONE_Q30         = TW'(1073741824);

	// atan(2^-i) in degrees times 65536.
	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
		25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
		25'sd917,     25'sd458,     25'sd229,    25'sd115
	};

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [COEF_W-1:0]     coef_t;
	typedef logic signed [TW-1:0]         trig_t;
	typedef logic signed [PW-1:0]         prod_t;

	typedef struct packed {
		angle_t first_angle;
		angle_t second_angle;
		angle_t third_angle;
	} in_t;

	typedef struct packed {
		coef_t m00;
		coef_t m01;
		coef_t m02;
		coef_t m10;
		coef_t m11;
		coef_t m12;
		coef_t m20;
		coef_t m21;
		coef_t m22;
	} out_t;

	// Round a Q60 value half up to the output precision and saturate at plus or minus one.
	function automatic coef_t finish(input prod_t v);
		prod_t r;
		prod_t one;
		begin
			one = prod_t'(1) <<< COEF_FRAC_BITS;
			r   = (v + (prod_t'(1) <<< (59 - COEF_FRAC_BITS))) >>> (60 - COEF_FRAC_BITS);
			if (r > one) begin
				r = one;
			end else if (r < -one) begin
				r = -one;
			end
			return r[COEF_W-1:0];
		end
	endfunction

	// Round a Q60 product to Q30.
	function automatic trig_t round_q30(input prod_t v);
		prod_t r;
		begin
			r = (v + (prod_t'(1) <<< 29)) >>> 30;
			return r[TW-1:0];
		end
	endfunction

endpackage
`default_nettype wire

[src/euler_to_rotation_matrix_core.sv]
// Euler angles to 3x3 rotation matrix, twelve-stage pipeline.
// Depends on e2rm_pkg for the payload structs, constants and rounding helpers.
//
// Usage: a request on the input channel carries three angles in degrees times
// 64 (two's complement). Each angle is wrapped into one turn, split into a
// quadrant and a remainder, and its sine and cosine are taken with a 16-step
// CORDIC at 30 fraction bits. The nine matrix entries are formed row major
// and delivered as Q1.14 values, rounded half up and clamped to plus or
// minus one, as one request on the output channel.
//
// There are 12 register stages, and throughput is one request per cycle
// while the receiver keeps out_ready high: stages 1 to 4 wrap the angle
// (offset, reciprocal multiply, remainder, correction and quadrant split),
// stages 5 to 8 each run four CORDIC steps on all three angles, stage 9
// maps the quadrant, stages 10 and 11 hold the two levels of products, and
// stage 12 sums, rounds and clamps into the output register.
//
// Every stage has its own valid bit and loads whenever it is empty or the
// next stage takes its contents, so bubbles close up and a stalled receiver
// holds the output register while earlier stages keep filling. Reset clears
// all valid bits; data registers are not reset.
`default_nettype none
module euler_to_rotation_matrix_core
	import e2rm_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire       out_ready,
	output out_t      out_data
);

	localparam int NST = 12;

	logic [NST:1] vld_q;
	logic [NST:1] rdy;

	always_comb begin
		rdy[NST] = !vld_q[NST] || out_ready;
		for (int k = NST - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NST];

	// Stage 1: shift each angle to a non-negative value by a whole number of turns.
	angle_t ang [3];
	assign ang[0] = in_data.first_angle;
	assign ang[1] = in_data.second_angle;
	assign ang[2] = in_data.third_angle;

	logic [UW-1:0] u_s1 [3];
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int l = 0; l < 3; l++) begin
				u_s1[l] <= UW'((UW+1)'(ang[l]) + (UW+1)'(ANG_OFFSET));
			end
		end
	end

	// Stage 2: quotient estimate by reciprocal multiply, low by at most one.
	logic [UW-1:0] u_s2 [3];
	logic [QW-1:0] qe_s2 [3];
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int l = 0; l < 3; l++) begin
				u_s2[l]  <= u_s1[l];
				qe_s2[l] <= QW'(((UW+RW)'(u_s1[l]) * (UW+RW)'(RECIP)) >> RSH);
			end
		end
	end

	// Stage 3: remainder below two turns.
	logic [15:0] rem_s3 [3];
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int l = 0; l < 3; l++) begin
				rem_s3[l] <= 16'(u_s2[l] - UW'(qe_s2[l]) * UW'(TURN_UNITS));
			end
		end
	end

	// Stage 4: final correction, quadrant split and scaling to degrees times 2^16.
	logic [15:0]          remc [3];
	logic [1:0]           quad [3];
	logic [15:0]          rq   [3];
	logic [1:0]           quad_s4 [3];
	logic signed [ZW-1:0] z_s4 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			remc[l] = (rem_s3[l] >= 16'(TURN_UNITS)) ? rem_s3[l] - 16'(TURN_UNITS) : rem_s3[l];
			if (remc[l] >= 16'(3 * QUARTER_UNITS)) begin
				quad[l] = 2'd3;
				rq[l]   = remc[l] - 16'(3 * QUARTER_UNITS);
			end else if (remc[l] >= 16'(2 * QUARTER_UNITS)) begin
				quad[l] = 2'd2;
				rq[l]   = remc[l] - 16'(2 * QUARTER_UNITS);
			end else if (remc[l] >= 16'(QUARTER_UNITS)) begin
				quad[l] = 2'd1;
				rq[l]   = remc[l] - 16'(QUARTER_UNITS);
			end else begin
				quad[l] = 2'd0;
				rq[l]   = remc[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int l = 0; l < 3; l++) begin
				quad_s4[l] <= quad[l];
				z_s4[l]    <= ZW'({rq[l][12:0], 10'b0});
			end
		end
	end

	// Stages 5 to 8: four rotation-mode CORDIC steps per stage.
	logic signed [XW-1:0] cx_s [1:CORDIC_STAGES][3];
	logic signed [XW-1:0] cy_s [1:CORDIC_STAGES][3];
	logic signed [ZW-1:0] cz_s [1:CORDIC_STAGES][3];
	logic [1:0]           cq_s [1:CORDIC_STAGES][3];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		logic signed [XW-1:0] x_in [3];
		logic signed [XW-1:0] y_in [3];
		logic signed [ZW-1:0] z_in [3];
		logic [1:0]           q_in [3];
		logic signed [XW-1:0] x [STEPS_PER_STAGE+1][3];
		logic signed [XW-1:0] y [STEPS_PER_STAGE+1][3];
		logic signed [ZW-1:0] z [STEPS_PER_STAGE+1][3];

		// The first CORDIC stage starts from the gain on the x axis.
		if (g == 0) begin : g_head
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					x_in[l] = CORDIC_GAIN_Q30;
					y_in[l] = '0;
					z_in[l] = z_s4[l];
					q_in[l] = quad_s4[l];
				end
			end
		end else begin : g_tail
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					x_in[l] = cx_s[g][l];
					y_in[l] = cy_s[g][l];
					z_in[l] = cz_s[g][l];
					q_in[l] = cq_s[g][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				x[0][l] = x_in[l];
				y[0][l] = y_in[l];
				z[0][l] = z_in[l];
				for (int k = 0; k < STEPS_PER_STAGE; k++) begin
					if (z[k][l] >= 0) begin
						x[k+1][l] = x[k][l] - (y[k][l] >>> (g * STEPS_PER_STAGE + k));
						y[k+1][l] = y[k][l] + (x[k][l] >>> (g * STEPS_PER_STAGE + k));
						z[k+1][l] = z[k][l] - ATAN_TAB[g * STEPS_PER_STAGE + k];
					end else begin
						x[k+1][l] = x[k][l] + (y[k][l] >>> (g * STEPS_PER_STAGE + k));
						y[k+1][l] = y[k][l] - (x[k][l] >>> (g * STEPS_PER_STAGE + k));
						z[k+1][l] = z[k][l] + ATAN_TAB[g * STEPS_PER_STAGE + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[5 + g]) begin
				for (int l = 0; l < 3; l++) begin
					cx_s[g+1][l] <= x[STEPS_PER_STAGE][l];
					cy_s[g+1][l] <= y[STEPS_PER_STAGE][l];
					cz_s[g+1][l] <= z[STEPS_PER_STAGE][l];
					cq_s[g+1][l] <= q_in[l];
				end
			end
		end
	end

	// Stage 9: clamp to the first quadrant range and map by quadrant.
	trig_t cc0 [3];
	trig_t ss0 [3];
	trig_t sin_s9 [3];
	trig_t cos_s9 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (cx_s[CORDIC_STAGES][l] < 0) begin
				cc0[l] = '0;
			end else if (cx_s[CORDIC_STAGES][l] > XW'(ONE_Q30)) begin
				cc0[l] = ONE_Q30;
			end else begin
				cc0[l] = TW'(cx_s[CORDIC_STAGES][l]);
			end
			if (cy_s[CORDIC_STAGES][l] < 0) begin
				ss0[l] = '0;
			end else if (cy_s[CORDIC_STAGES][l] > XW'(ONE_Q30)) begin
				ss0[l] = ONE_Q30;
			end else begin
				ss0[l] = TW'(cy_s[CORDIC_STAGES][l]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			for (int l = 0; l < 3; l++) begin
				unique case (cq_s[CORDIC_STAGES][l])
					2'd0: begin
						sin_s9[l] <= ss0[l];
						cos_s9[l] <= cc0[l];
					end
					2'd1: begin
						sin_s9[l] <= cc0[l];
						cos_s9[l] <= -ss0[l];
					end
					2'd2: begin
						sin_s9[l] <= -ss0[l];
						cos_s9[l] <= -cc0[l];
					end
					default: begin
						sin_s9[l] <= -cc0[l];
						cos_s9[l] <= ss0[l];
					end
				endcase
			end
		end
	end

	// Lane 0 is angle a, lane 1 is b, lane 2 is c.
	trig_t sa, ca, sb, cb, sc, cc;
	assign sa = sin_s9[0];
	assign ca = cos_s9[0];
	assign sb = sin_s9[1];
	assign cb = cos_s9[1];
	assign sc = sin_s9[2];
	assign cc = cos_s9[2];

	// Stage 10: all two-factor products; the leading pairs of the triple products
	// are rounded back to Q30.
	trig_t ccsb_s10, scsb_s10, sa_s10, ca_s10, sb_s10;
	prod_t cccb_s10, sccb_s10, cbsa_s10, cbca_s10, scca_s10, scsa_s10, ccca_s10, ccsa_s10;

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			ccsb_s10 <= round_q30(PW'(cc) * PW'(sb));
			scsb_s10 <= round_q30(PW'(sc) * PW'(sb));
			cccb_s10 <= PW'(cc) * PW'(cb);
			sccb_s10 <= PW'(sc) * PW'(cb);
			cbsa_s10 <= PW'(cb) * PW'(sa);
			cbca_s10 <= PW'(cb) * PW'(ca);
			scca_s10 <= PW'(sc) * PW'(ca);
			scsa_s10 <= PW'(sc) * PW'(sa);
			ccca_s10 <= PW'(cc) * PW'(ca);
			ccsa_s10 <= PW'(cc) * PW'(sa);
			sa_s10   <= sa;
			ca_s10   <= ca;
			sb_s10   <= sb;
		end
	end

	// Stage 11: third factor of the triple products.
	prod_t t1_s11, t2_s11, t4_s11, t5_s11;
	prod_t cccb_s11, sccb_s11, cbsa_s11, cbca_s11, scca_s11, scsa_s11, ccca_s11, ccsa_s11;
	prod_t sb_s11;

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			t1_s11   <= PW'(ccsb_s10) * PW'(sa_s10);
			t2_s11   <= PW'(ccsb_s10) * PW'(ca_s10);
			t4_s11   <= PW'(scsb_s10) * PW'(sa_s10);
			t5_s11   <= PW'(scsb_s10) * PW'(ca_s10);
			cccb_s11 <= cccb_s10;
			sccb_s11 <= sccb_s10;
			cbsa_s11 <= cbsa_s10;
			cbca_s11 <= cbca_s10;
			scca_s11 <= scca_s10;
			scsa_s11 <= scsa_s10;
			ccca_s11 <= ccca_s10;
			ccsa_s11 <= ccsa_s10;
			sb_s11   <= PW'(sb_s10) <<< 30;
		end
	end

	// Stage 12: sums, rounding and saturation into the output register.
	out_t out_s12;
	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			out_s12.m00 <= finish(cccb_s11);
			out_s12.m01 <= finish(scca_s11 + t1_s11);
			out_s12.m02 <= finish(scsa_s11 + t2_s11);
			out_s12.m10 <= finish(-sccb_s11);
			out_s12.m11 <= finish(ccca_s11 - t4_s11);
			out_s12.m12 <= finish(ccsa_s11 + t5_s11);
			out_s12.m20 <= finish(sb_s11);
			out_s12.m21 <= finish(-cbsa_s11);
			out_s12.m22 <= finish(cbca_s11);
		end
	end

	assign out_data = out_s12;

endmodule
`default_nettype wire
